### rtl/cgpg_pkg.sv
package cgpg_pkg;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int T_BITS = 17;
  localparam logic [T_BITS-1:0] T_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RADIAL_MODE = 3'd0,
    REG_COLOR_START = 3'd1,
    REG_COLOR_END   = 3'd2,
    REG_PARAM_X     = 3'd3,
    REG_PARAM_Y     = 3'd4,
    REG_OFFSET      = 3'd5,
    REG_SPAN        = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       alpha_used;
  } pix_color_t;

endpackage

### rtl/cgpg_pix_if.sv
interface cgpg_pix_if #(
  parameter int COORD_BITS = 15
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;

  modport source (output valid, pix_x, pix_y, input ready);
  modport sink   (input valid, pix_x, pix_y, output ready);
endinterface

### rtl/cgpg_color_if.sv
interface cgpg_color_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] alpha;
  logic       alpha_used;

  modport source (output valid, blue, green, red, alpha, alpha_used, input ready);
  modport sink   (input valid, blue, green, red, alpha, alpha_used, output ready);
endinterface

### rtl/cgpg_cfg_if.sv
interface cgpg_cfg_if;
  import cgpg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/color_gradient_pixel_generator.sv
// Gradient fill pixel generator. Each input beat carries one pixel coordinate and
// yields one color beat. Linear mode projects the pixel on (param_x, param_y),
// subtracts offset and divides by span; radial mode takes the distance to the
// center (param_x, param_y) and divides by span. The blend position is clamped
// to [0, 1.0] in Q1.16 and each channel is floor(start*(1-t) + end*t). One pixel
// is accepted every clock unless the output stalls; it passes the 32-stage square
// root pipeline and the 16-stage restoring divider. The whole pipeline advances
// together and holds when the output beat is not taken. Configuration writes are
// always accepted and must only happen while no pixel is in flight.
module color_gradient_pixel_generator #(
  parameter int COORD_BITS = 15,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  cgpg_pix_if.sink     in_ch,
  cgpg_color_if.source out_ch,
  cgpg_cfg_if.sink     cfg_ch
);
  import cgpg_pkg::*;

  localparam int SQ_N = 32;
  localparam int DIV_N = 16;
  localparam int PW = COORD_BITS + 33;          // coord * param product
  localparam int NW = PW + 2;                   // projection minus offset
  localparam int XW = (COORD_BITS + FRAC_BITS > 32) ? COORD_BITS + FRAC_BITS : 32;
  localparam int DW = XW + 2;                   // signed axis difference
  localparam logic [30:0] SP_ONE = 31'(1) << FRAC_BITS;

  // configuration registers
  logic               radial_mode_r;
  logic [31:0]        color_start_r, color_end_r;
  logic signed [31:0] param_x_r, param_y_r, offset_r;
  logic [30:0]        span_r;
  logic [30:0]        sp;

  assign cfg_ch.ready = 1'b1;
  assign sp = (span_r == '0) ? SP_ONE : span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radial_mode_r <= 1'b0;
      color_start_r <= 32'h0000_00FF;
      color_end_r   <= 32'hFFFF_FFFF;
      param_x_r     <= 32'sd1 <<< FRAC_BITS;
      param_y_r     <= '0;
      offset_r      <= '0;
      span_r        <= SP_ONE;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RADIAL_MODE: radial_mode_r <= cfg_ch.data[0];
        REG_COLOR_START: color_start_r <= cfg_ch.data;
        REG_COLOR_END:   color_end_r   <= cfg_ch.data;
        REG_PARAM_X:     param_x_r     <= signed'(cfg_ch.data);
        REG_PARAM_Y:     param_y_r     <= signed'(cfg_ch.data);
        REG_OFFSET:      offset_r      <= signed'(cfg_ch.data);
        REG_SPAN:        span_r        <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  // global advance: every stage moves when the output slot frees up
  logic out_v_r;
  logic en;
  assign en = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---- stage 1: products and axis differences
  logic signed [PW-1:0] p1_nxt, p2_nxt, p1_r, p2_r;
  logic signed [DW-1:0] dx, dy, px_w, py_w;
  logic [DW-2:0]        ax_nxt, ay_nxt, ax_r, ay_r;
  logic                 v1_r;

  always_comb begin
    p1_nxt = signed'({1'b0, in_ch.pix_x}) * param_x_r;
    p2_nxt = signed'({1'b0, in_ch.pix_y}) * param_y_r;
    px_w = DW'(param_x_r);
    py_w = DW'(param_y_r);
    dx = signed'(DW'({in_ch.pix_x, {FRAC_BITS{1'b0}}})) - px_w;
    dy = signed'(DW'({in_ch.pix_y, {FRAC_BITS{1'b0}}})) - py_w;
    ax_nxt = dx[DW-1] ? (DW-1)'(-dx) : dx[DW-2:0];
    ay_nxt = dy[DW-1] ? (DW-1)'(-dy) : dy[DW-2:0];
  end

  // ---- stage 2: linear classify, radial squares
  logic signed [NW-1:0] num;
  logic                 lin_zero_r, lin_one_r, rbig_r, v2_r;
  logic [30:0]          lin_d_r;
  logic [61:0]          sqx_r, sqy_r;

  assign num = NW'(p1_r) + NW'(p2_r) - NW'(offset_r);

  // ---- square root pipeline, index 0 is stage 3
  logic [63:0] sv_r   [0:SQ_N];
  logic [63:0] sr_r   [0:SQ_N];
  logic [30:0] sd_r   [0:SQ_N];
  logic        sone_r [0:SQ_N];
  logic        szero_r[0:SQ_N];
  logic        svld_r [0:SQ_N];

  // ---- divider pipeline
  logic [31:0] drem_r [0:DIV_N];
  logic [15:0] dq_r   [0:DIV_N];
  logic        done_r [0:DIV_N];
  logic        dzero_r[0:DIV_N];
  logic        dvld_r [0:DIV_N];

  logic [31:0] rad_dist;
  assign rad_dist = sr_r[SQ_N][31:0];

  logic [T_BITS-1:0] t_r;
  logic              tv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      svld_r[0] <= 1'b0;
      dvld_r[0] <= 1'b0;
      tv_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      svld_r[0] <= v2_r;
      dvld_r[0] <= svld_r[SQ_N];
      tv_r <= dvld_r[DIV_N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      // stage 2
      lin_zero_r <= (num <= 0);
      lin_one_r  <= (num >= signed'(NW'(sp)));
      lin_d_r    <= num[30:0];
      rbig_r     <= (ax_r >= (DW-1)'(sp)) || (ay_r >= (DW-1)'(sp));
      sqx_r      <= ax_r[30:0] * ax_r[30:0];
      sqy_r      <= ay_r[30:0] * ay_r[30:0];
      // stage 3
      sv_r[0]    <= 64'(sqx_r) + 64'(sqy_r);
      sr_r[0]    <= '0;
      sd_r[0]    <= lin_d_r;
      sone_r[0]  <= radial_mode_r ? rbig_r : lin_one_r;
      szero_r[0] <= radial_mode_r ? 1'b0 : lin_zero_r;
      // divider entry: pick dividend, saturate on distance past span
      drem_r[0]  <= {1'b0, (radial_mode_r ? rad_dist[30:0] : sd_r[SQ_N])};
      dq_r[0]    <= '0;
      done_r[0]  <= sone_r[SQ_N] || (radial_mode_r && (rad_dist >= 32'(sp)));
      dzero_r[0] <= szero_r[SQ_N];
      // blend position
      t_r <= dzero_r[DIV_N] ? '0 : (done_r[DIV_N] ? T_ONE : T_BITS'(dq_r[DIV_N]));
    end
  end

  // one result bit per square root stage
  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
    logic [63:0] trial;
    logic        take;
    assign trial = sr_r[i] + BIT;
    assign take  = sv_r[i] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        svld_r[i+1] <= 1'b0;
      end else if (en) begin
        svld_r[i+1] <= svld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sv_r[i+1]    <= take ? sv_r[i] - trial : sv_r[i];
        sr_r[i+1]    <= take ? (sr_r[i] >> 1) + BIT : sr_r[i] >> 1;
        sd_r[i+1]    <= sd_r[i];
        sone_r[i+1]  <= sone_r[i];
        szero_r[i+1] <= szero_r[i];
      end
    end
  end

  // restoring divide, one quotient bit per stage; remainder stays below span when the position is not clamped
  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    logic [31:0] r2;
    logic        ge;
    assign r2 = {drem_r[i][30:0], 1'b0};
    assign ge = r2 >= 32'(sp);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvld_r[i+1] <= 1'b0;
      end else if (en) begin
        dvld_r[i+1] <= dvld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[i+1]  <= ge ? r2 - 32'(sp) : r2;
        dq_r[i+1]    <= {dq_r[i][14:0], ge};
        done_r[i+1]  <= done_r[i];
        dzero_r[i+1] <= dzero_r[i];
      end
    end
  end

  // ---- blend and output register
  function automatic logic [7:0] blend8(input logic [7:0] s, input logic [7:0] e,
                                        input logic [T_BITS-1:0] t);
    logic [24:0] acc;
    acc = 25'(s) * 25'(T_ONE - t) + 25'(e) * 25'(t);
    return acc[23:16];
  endfunction

  pix_color_t col_nxt, col_r;

  always_comb begin
    col_nxt.blue  = blend8(color_start_r[15:8], color_end_r[15:8], t_r);
    col_nxt.green = blend8(color_start_r[23:16], color_end_r[23:16], t_r);
    col_nxt.red   = blend8(color_start_r[31:24], color_end_r[31:24], t_r);
    col_nxt.alpha = blend8(color_start_r[7:0], color_end_r[7:0], t_r);
    col_nxt.alpha_used = (color_start_r[7:0] != 8'hFF) || (color_end_r[7:0] != 8'hFF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= tv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      col_r <= col_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.blue       = col_r.blue;
  assign out_ch.green      = col_r.green;
  assign out_ch.red        = col_r.red;
  assign out_ch.alpha      = col_r.alpha;
  assign out_ch.alpha_used = col_r.alpha_used;

  // ---- checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ch.ready)
    else $error("input stalled with empty output slot");

  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_v_r)
    else $error("output beat right after reset");

  a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    tv_r |-> t_r <= T_ONE)
    else $error("blend position above one");

  a_opaque_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !col_r.alpha_used |-> col_r.alpha == 8'hFF)
    else $error("alpha not opaque while unused");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_v_r && !out_ch.ready) |-> out_v_r && $stable(col_r))
    else $error("stalled beat changed");

endmodule

### dv/cgpg_gradient_checker.sv
`timescale 1ns / 100ps
module cgpg_gradient_checker (
  input  logic clk,
  input  logic rst_n,
  cgpg_pix_if.sink   pix_mon,
  cgpg_color_if.sink color_mon,
  cgpg_cfg_if.sink   cfg_mon,
  output int         fail_count,
  output int         pending_count
);
  import cgpg_pkg::*;

  logic        mode_radial;
  logic [31:0] col_start, col_end;
  logic [31:0] geo_x, geo_y, geo_off;
  logic [30:0] geo_span;

  pix_color_t color_queue[$];

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bit_w;
    res = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] mix8(input logic [7:0] s, input logic [7:0] e,
                                      input logic [16:0] t);
    logic [63:0] acc;
    acc = 64'(s) * (64'd65536 - 64'(t)) + 64'(e) * 64'(t);
    return acc[23:16];
  endfunction

  function automatic pix_color_t gradient_color(input logic [14:0] px, input logic [14:0] py);
    longint sx, sy, cx, cy, num, ax, ay;
    logic [63:0] sp, dist_v;
    logic [16:0] t;
    pix_color_t c;
    sp = (geo_span == 0) ? 64'd65536 : 64'(geo_span);
    cx = longint'($signed(geo_x));
    cy = longint'($signed(geo_y));
    sx = longint'(px);
    sy = longint'(py);
    if (!mode_radial) begin
      num = sx * cx + sy * cy - longint'($signed(geo_off));
      if (num <= 0) t = '0;
      else if (64'(num) >= sp) t = T_ONE;
      else t = 17'((64'(num) << 16) / sp);
    end else begin
      ax = (sx << 16) - cx;
      ay = (sy << 16) - cy;
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (64'(ax) >= sp || 64'(ay) >= sp) t = T_ONE;
      else begin
        dist_v = int_sqrt(64'(ax) * 64'(ax) + 64'(ay) * 64'(ay));
        t = (dist_v >= sp) ? T_ONE : 17'((dist_v << 16) / sp);
      end
    end
    c.blue  = mix8(col_start[15:8], col_end[15:8], t);
    c.green = mix8(col_start[23:16], col_end[23:16], t);
    c.red   = mix8(col_start[31:24], col_end[31:24], t);
    c.alpha = mix8(col_start[7:0], col_end[7:0], t);
    c.alpha_used = (col_start[7:0] != 8'hFF) || (col_end[7:0] != 8'hFF);
    return c;
  endfunction

  assign pending_count = color_queue.size();

  always @(posedge clk) begin
    pix_color_t want, got;
    if (!rst_n) begin
      mode_radial <= 1'b0;
      col_start <= 32'h0000_00FF;
      col_end <= 32'hFFFF_FFFF;
      geo_x <= 32'h0001_0000;
      geo_y <= '0;
      geo_off <= '0;
      geo_span <= 31'h0001_0000;
      fail_count <= 0;
      color_queue.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_RADIAL_MODE: mode_radial <= cfg_mon.data[0];
          REG_COLOR_START: col_start <= cfg_mon.data;
          REG_COLOR_END:   col_end <= cfg_mon.data;
          REG_PARAM_X:     geo_x <= cfg_mon.data;
          REG_PARAM_Y:     geo_y <= cfg_mon.data;
          REG_OFFSET:      geo_off <= cfg_mon.data;
          REG_SPAN:        geo_span <= cfg_mon.data[30:0];
          default: ;
        endcase
      end
      if (color_mon.valid && color_mon.ready) begin
        got = '{color_mon.blue, color_mon.green, color_mon.red, color_mon.alpha,
                color_mon.alpha_used};
        if (color_queue.size() == 0) begin
          $display("%0t: unexpected color beat %h", $realtime, got);
          fail_count <= fail_count + 1;
        end else begin
          want = color_queue.pop_front();
          if (got !== want) begin
            $display("%0t: color mismatch expected %h actual %h", $realtime, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (pix_mon.valid && pix_mon.ready)
        color_queue.push_back(gradient_color(pix_mon.pix_x, pix_mon.pix_y));
    end
  end
endmodule

### dv/color_gradient_pixel_generator_tb.sv
`timescale 1ns / 100ps
module color_gradient_pixel_generator_tb;
  import cgpg_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count;
  bit   calm;      // last part of the run: no idling on either side

  cgpg_pix_if #(.COORD_BITS(15)) pix_ch ();
  cgpg_color_if color_ch ();
  cgpg_cfg_if cfg_ch ();

  color_gradient_pixel_generator DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(pix_ch), .out_ch(color_ch), .cfg_ch(cfg_ch)
  );

  cgpg_gradient_checker u_checker (
    .clk(clk), .rst_n(rst_n), .pix_mon(pix_ch), .color_mon(color_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    pix_ch.valid = 1'b0;
    pix_ch.pix_x = '0;
    pix_ch.pix_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    color_ch.ready = 1'b0;
  end

  // Sink side: ready stalls in random bursts until the calm phase.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        color_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        color_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // One beat on the pixel channel; valid stays up across back-to-back beats.
  task automatic send_pixel(input logic [14:0] px, input logic [14:0] py);
    if (!calm && $urandom_range(0, 7) == 0) begin
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pix_x <= px;
    pix_ch.pix_y <= py;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  task automatic end_burst();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain the pipeline before touching registers.
  task automatic wait_idle();
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Small coordinate, mostly near where gradients live, sometimes full range.
  function automatic logic [14:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return 15'($urandom);
    return 15'($urandom_range(0, 300));
  endfunction

  function automatic logic [31:0] rand_color();
    logic [31:0] c;
    c = $urandom;
    if ($urandom_range(0, 1)) c[7:0] = 8'hFF;
    return c;
  endfunction

  // Random but meaningful geometry; extremes now and then.
  task automatic program_random();
    logic [31:0] ang;
    write_reg(REG_RADIAL_MODE, 32'($urandom_range(0, 1)));
    write_reg(REG_COLOR_START, rand_color());
    write_reg(REG_COLOR_END, rand_color());
    case ($urandom_range(0, 4))
      0: begin
        write_reg(REG_PARAM_X, $urandom);
        write_reg(REG_PARAM_Y, $urandom);
        write_reg(REG_OFFSET, $urandom);
        write_reg(REG_SPAN, $urandom);
      end
      default: begin
        ang = 32'($signed($urandom_range(0, 131072)) - 65536);
        write_reg(REG_PARAM_X, ang);
        write_reg(REG_PARAM_Y, 32'($signed($urandom_range(0, 131072)) - 65536));
        write_reg(REG_OFFSET, 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16)));
        write_reg(REG_SPAN, $urandom_range(0, 400 << 16));
      end
    endcase
  endtask

  initial begin
    calm = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset setting, coordinate extremes.
    send_pixel(15'd0, 15'd0);
    send_pixel(15'h7FFF, 15'h7FFF);
    send_pixel(15'h7FFF, 15'd0);
    send_pixel(15'd0, 15'h7FFF);
    send_pixel(15'h5555, 15'h2AAA);
    end_burst();
    wait_idle();

    // Linear, zero span (treated as 1.0), negative direction, offset mid.
    write_reg(REG_COLOR_START, 32'h12345678);
    write_reg(REG_COLOR_END, 32'hFEDCBAFF);
    write_reg(REG_PARAM_X, 32'hFFFF_0000);
    write_reg(REG_PARAM_Y, 32'h0000_8000);
    write_reg(REG_OFFSET, 32'hFFF0_0000);
    write_reg(REG_SPAN, 32'd0);
    send_pixel(15'd0, 15'd0);
    send_pixel(15'd16, 15'd0);
    send_pixel(15'd15, 15'd0);
    end_burst();
    wait_idle();
    write_reg(REG_SPAN, 32'h7FFF_FFFF);
    send_pixel(15'd3, 15'd9);
    send_pixel(15'h7FFF, 15'h7FFF);
    end_burst();
    wait_idle();

    // Radial: inside, on axis clamp, far, extremes of center.
    write_reg(REG_RADIAL_MODE, 32'd1);
    write_reg(REG_PARAM_X, 32'h0064_0000);
    write_reg(REG_PARAM_Y, 32'h0064_0000);
    write_reg(REG_SPAN, 32'h0032_0000);
    send_pixel(15'd100, 15'd100);
    send_pixel(15'd130, 15'd130);
    send_pixel(15'd150, 15'd100);
    send_pixel(15'd110, 15'd95);
    send_pixel(15'h7FFF, 15'h7FFF);
    end_burst();
    wait_idle();
    write_reg(REG_PARAM_X, 32'h8000_0000);
    write_reg(REG_PARAM_Y, 32'h7FFF_FFFF);
    write_reg(REG_SPAN, 32'h7FFF_FFFF);
    send_pixel(15'd0, 15'h7FFF);
    send_pixel(15'h7FFF, 15'd0);
    end_burst();
    wait_idle();

    // Random phases; last ones run without idling.
    for (int ph = 0; ph < 30; ph++) begin
      if (ph >= 26) calm = 1'b1;
      program_random();
      repeat (60) send_pixel(rand_coord(), rand_coord());
      end_burst();
      wait_idle();
    end

    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("FAILURE");
    $finish;
  end
endmodule

### color_gradient_pixel_generator.f
rtl/cgpg_pkg.sv
rtl/cgpg_pix_if.sv
rtl/cgpg_color_if.sv
rtl/cgpg_cfg_if.sv
rtl/color_gradient_pixel_generator.sv
dv/cgpg_gradient_checker.sv
dv/color_gradient_pixel_generator_tb.sv
